>>> src/psft_pkg.sv
// ----------------------------------------------------------------------------
// psft_pkg
// Shared types and constants for the smallest-prime-factor sieve table.
// ----------------------------------------------------------------------------
`default_nettype none

package psft_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 65536;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int SQ_W          = 2 * ADDR_W;

    // Field widths fixed by the interface
    localparam int NUM_W    = 16;
    localparam int LIMIT_W  = 16;
    localparam int FACTOR_W = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

    typedef enum logic {
        OP_BUILD = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_NOBUILD = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QRD,
        S_INIT,
        S_SQ,
        S_RDI,
        S_CHKI,
        S_MARK
    } t_state;

    // Request bundle from the sequencer to the table memory
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // Clip the configured limit to the last table entry
    function automatic logic [ADDR_W-1:0] cap_limit(input logic [LIMIT_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 > 32'(TABLE_ENTRIES - 1)) begin
            return ADDR_W'(TABLE_ENTRIES - 1);
        end
        return ADDR_W'(v32);
    endfunction

endpackage

`default_nettype wire

>>> src/prime_sieve_factor_table_top.sv
// ----------------------------------------------------------------------------
// prime_sieve_factor_table_top
// Smallest-prime-factor table: a build word sieves the table up to the
// configured limit, a query word returns one number's factor and prime flag.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                 Payload
// s (in)    in   i_s_tvalid / o_s_tready   tuser: operation; tdata: number
// m (out)   out  o_m_tvalid / i_m_tready   tuser: status; tdata: is_prime,
//                                          smallest_factor
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_data: sieve_limit
//
// Query: the entry is read from the table memory with registered read data,
// and the result word is formed in S_QRD; when not built or out of range the
// result word is posted straight from idle. Build with limit L: entries 0..L
// are filled with their own index, each candidate i with i*i <= L is squared,
// read and checked, multiples of each prime i are marked from i*i up to L with
// one entry read and one written per cycle, and the build word is posted once
// i*i passes L. No input word is taken until the build result is posted.
// Reset: synchronous, active low; no clearing pass, the table is written by
// every build before any query reads it.
// The result register frees the input side as soon as the pending word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_sieve_factor_table_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [15:0] number
    input  wire logic        i_s_tuser,   // [0] operation
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [23:0] o_m_tdata,   // [0] is_prime, [16:1] smallest_factor
    output logic      [1:0]  o_m_tuser,   // [1:0] status
    // configuration
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data   // [15:0] sieve_limit
);

    logic [psft_pkg::LIMIT_W-1:0]  r_sieve_limit;
    psft_pkg::t_mem_req            w_mem;
    logic [psft_pkg::ADDR_W-1:0]   w_rdata;
    psft_pkg::t_status             w_status;
    logic                          w_is_prime;
    logic [psft_pkg::FACTOR_W-1:0] w_factor;

    // Configuration register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sieve_limit <= psft_pkg::LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sieve_limit <= i_cfg_data;
        end
    end

    psft_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_s_tvalid),
        .o_in_ready    (o_s_tready),
        .i_op          (i_s_tuser),
        .i_num         (i_s_tdata),
        .i_sieve_limit (r_sieve_limit),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_status      (w_status),
        .o_is_prime    (w_is_prime),
        .o_factor      (w_factor),
        .o_mem         (w_mem),
        .i_rdata       (w_rdata)
    );

    psft_ram #(
        .DEPTH (psft_pkg::TABLE_ENTRIES),
        .WIDTH (psft_pkg::ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_re    (w_mem.re),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    // Pack the result word
    assign o_m_tuser = w_status;
    assign o_m_tdata = {7'b0, w_factor, w_is_prime};

endmodule

`default_nettype wire

>>> src/psft_ram.sv
// ----------------------------------------------------------------------------
// psft_ram
// Simple dual-port synchronous RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module psft_ram #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/psft_ctrl.sv
// ----------------------------------------------------------------------------
// psft_ctrl
// Sequencer: fills and sieves the factor table on a build word, looks up one
// entry on a query word, and holds the result word in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psft_ctrl (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input word
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_op,
    input  wire logic [psft_pkg::NUM_W-1:0]       i_num,
    // current configured limit
    input  wire logic [psft_pkg::LIMIT_W-1:0]     i_sieve_limit,
    // result word
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output psft_pkg::t_status                     o_status,
    output logic                                  o_is_prime,
    output logic      [psft_pkg::FACTOR_W-1:0]    o_factor,
    // table memory
    output psft_pkg::t_mem_req                    o_mem,
    input  wire logic [psft_pkg::ADDR_W-1:0]      i_rdata
);

    localparam int AW = psft_pkg::ADDR_W;
    localparam int SW = psft_pkg::SQ_W;

    psft_pkg::t_state  r_state, n_state;
    logic [AW-1:0]     r_lim, n_lim;
    logic [AW-1:0]     r_a, n_a;
    logic [AW-1:0]     r_i, n_i;
    logic [SW-1:0]     r_sq, n_sq;
    logic [AW:0]       r_j, n_j;
    logic [AW-1:0]     r_pj, n_pj;
    logic              r_pend, n_pend;
    logic [psft_pkg::NUM_W-1:0] r_num, n_num;
    logic              r_built, n_built;
    logic [AW-1:0]     r_blim, n_blim;
    logic              r_out_valid, n_out_valid;
    psft_pkg::t_status r_out_status, n_out_status;
    logic              r_out_prime, n_out_prime;
    logic [psft_pkg::FACTOR_W-1:0] r_out_factor, n_out_factor;
    logic              w_slot_free;
    logic              w_accept;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == psft_pkg::S_IDLE) && w_slot_free;
    assign w_accept    = i_in_valid && o_in_ready;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_is_prime  = r_out_prime;
    assign o_factor    = r_out_factor;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psft_pkg::S_IDLE;
            r_pend      <= 1'b0;
            r_built     <= 1'b0;
            r_blim      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_built     <= n_built;
            r_blim      <= n_blim;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_lim        <= n_lim;
        r_a          <= n_a;
        r_i          <= n_i;
        r_sq         <= n_sq;
        r_j          <= n_j;
        r_pj         <= n_pj;
        r_num        <= n_num;
        r_out_status <= n_out_status;
        r_out_prime  <= n_out_prime;
        r_out_factor <= n_out_factor;
    end

    // Next state, memory requests, result word
    always_comb begin
        n_state      = r_state;
        n_lim        = r_lim;
        n_a          = r_a;
        n_i          = r_i;
        n_sq         = r_sq;
        n_j          = r_j;
        n_pj         = r_pj;
        n_pend       = r_pend;
        n_num        = r_num;
        n_built      = r_built;
        n_blim       = r_blim;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_prime  = r_out_prime;
        n_out_factor = r_out_factor;
        o_mem        = '0;

        // drop the result word once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            psft_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (psft_pkg::t_op'(i_op))
                        psft_pkg::OP_BUILD: begin
                            n_lim   = psft_pkg::cap_limit(i_sieve_limit);
                            n_a     = '0;
                            n_state = psft_pkg::S_INIT;
                        end
                        psft_pkg::OP_QUERY: begin
                            if (!r_built) begin
                                n_out_valid  = 1'b1;
                                n_out_status = psft_pkg::ST_NOBUILD;
                                n_out_prime  = 1'b0;
                                n_out_factor = '0;
                            end else if (32'(i_num) > 32'(r_blim)) begin
                                n_out_valid  = 1'b1;
                                n_out_status = psft_pkg::ST_RANGE;
                                n_out_prime  = 1'b0;
                                n_out_factor = '0;
                            end else begin
                                o_mem.re    = 1'b1;
                                o_mem.raddr = AW'(i_num);
                                n_num       = i_num;
                                n_state     = psft_pkg::S_QRD;
                            end
                        end
                        default: begin
                            n_state = psft_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            // entry arrives; form the query result
            psft_pkg::S_QRD: begin
                n_out_valid  = 1'b1;
                n_out_status = psft_pkg::ST_OK;
                n_out_factor = psft_pkg::FACTOR_W'(i_rdata);
                n_out_prime  = (r_num >= psft_pkg::NUM_W'(2))
                               && (32'(i_rdata) == 32'(r_num));
                n_state      = psft_pkg::S_IDLE;
            end

            // write each entry with its own index
            psft_pkg::S_INIT: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_a;
                o_mem.wdata = r_a;
                if (r_a == r_lim) begin
                    n_i     = AW'(2);
                    n_state = psft_pkg::S_SQ;
                end else begin
                    n_a = r_a + 1'b1;
                end
            end

            // square the candidate
            psft_pkg::S_SQ: begin
                n_sq    = SW'(r_i) * SW'(r_i);
                n_state = psft_pkg::S_RDI;
            end

            // stop once i*i passes the limit, else fetch entry i
            psft_pkg::S_RDI: begin
                if (r_sq > SW'(r_lim)) begin
                    n_built      = 1'b1;
                    n_blim       = r_lim;
                    n_out_valid  = 1'b1;
                    n_out_status = psft_pkg::ST_OK;
                    n_out_prime  = 1'b0;
                    n_out_factor = '0;
                    n_state      = psft_pkg::S_IDLE;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_i;
                    n_state     = psft_pkg::S_CHKI;
                end
            end

            // still its own factor: mark multiples from i*i
            psft_pkg::S_CHKI: begin
                if (i_rdata == r_i) begin
                    n_j     = (AW+1)'(r_sq[AW-1:0]);
                    n_pend  = 1'b0;
                    n_state = psft_pkg::S_MARK;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = psft_pkg::S_SQ;
                end
            end

            // read j, write back min(entry, i) in the following cycle
            psft_pkg::S_MARK: begin
                if (r_pend) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_pj;
                    o_mem.wdata = (i_rdata > r_i) ? r_i : i_rdata;
                end
                if (r_j <= {1'b0, r_lim}) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_j[AW-1:0];
                    n_pj        = r_j[AW-1:0];
                    n_pend      = 1'b1;
                    n_j         = r_j + (AW+1)'(r_i);
                end else begin
                    n_pend  = 1'b0;
                    n_i     = r_i + 1'b1;
                    n_state = psft_pkg::S_SQ;
                end
            end

            default: begin
                n_state = psft_pkg::S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // No table write lands past the limit of the build in progress
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.we |-> o_mem.waddr <= r_lim)
        else $error("table write beyond build limit");

    // Fill pass writes the identity
    a_init_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psft_pkg::S_INIT) |-> (o_mem.we && o_mem.wdata == o_mem.waddr))
        else $error("fill pass wrote a non-identity entry");

    // Marking never touches entries below i*i
    a_mark_from_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psft_pkg::S_MARK && r_pend) |-> (SW'(r_pj) >= r_sq))
        else $error("marked entry below square of factor");

    // Result slot is empty while a query read is in flight
    a_slot_free_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psft_pkg::S_QRD) |-> !r_out_valid)
        else $error("query result would overwrite pending word");

    // Completing a build posts a done word
    a_build_done_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_built) |-> (r_out_valid && r_out_status == psft_pkg::ST_OK))
        else $error("build finished without result word");
`endif

endmodule

`default_nettype wire
